// ----- rtl/core/ghf_pkg.sv -----
// ----------------------------------------------------------------------------
// ghf_pkg
// Shared types and constants for the 3x3 masked-mean grid fill unit.
// ----------------------------------------------------------------------------
package ghf_pkg;

    localparam int COORD_W    = 9;
    localparam int IN_VALUE_W = 32;
    localparam int FILL_W     = 32;
    localparam int COUNT_W    = 4;
    localparam int SIZE_W     = 10;
    localparam int THR_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int DIV_STEP   = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 2'd2;

    localparam logic [SIZE_W-1:0] GRID_ROWS_RST = 10'd512;
    localparam logic [SIZE_W-1:0] GRID_COLS_RST = 10'd512;
    localparam logic [THR_W-1:0]  MIN_VALID_RST = 4'd5;

    typedef struct packed {
        logic clear_en;
        logic wr_en;
        logic q_load;
        logic rd_en;
        logic div_load;
        logic div_step;
        logic out_en;
    } ghf_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic win_last;
        logic div_last;
    } ghf_stat_t;

endpackage

// ----- rtl/core/ghf_ram.sv -----
// ----------------------------------------------------------------------------
// ghf_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module ghf_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/ghf_divider.sv -----
// ----------------------------------------------------------------------------
// ghf_divider
// Iterative signed-by-small-unsigned divider, truncating toward zero.
// DIV_STEP restoring steps per cycle while step is high, on a 4-bit remainder.
// ----------------------------------------------------------------------------
module ghf_divider #(
    parameter int SUM_W = 36
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              step,
    input  logic signed [SUM_W-1:0]           dividend,
    input  logic [ghf_pkg::COUNT_W-1:0]       divisor,
    output logic signed [SUM_W-1:0]           quotient,
    output logic                              last
);

    localparam int STEP   = ghf_pkg::DIV_STEP;
    localparam int ITER   = (SUM_W + STEP - 1) / STEP;
    localparam int PAD_W  = ITER * STEP;
    localparam int ITER_W = (ITER > 1) ? $clog2(ITER) : 1;
    localparam int REM_W  = ghf_pkg::COUNT_W + 1;

    logic [PAD_W-1:0]                quo_reg, quo_next;
    logic [ghf_pkg::COUNT_W-1:0]     rem_reg, rem_next;
    logic [ghf_pkg::COUNT_W-1:0]     den_reg;
    logic                            neg_reg;
    logic [ITER_W-1:0]               iter_reg;
    logic [SUM_W-1:0]                mag;
    logic [SUM_W-1:0]                quo_mag;

    assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    always_comb
    begin
        logic [REM_W-1:0] rem_v;
        logic [PAD_W-1:0] quo_v;
        rem_v = REM_W'(rem_reg);
        quo_v = quo_reg;
        for (int i = 0; i < STEP; i++)
        begin
            rem_v = {rem_v[REM_W-2:0], quo_v[PAD_W-1]};
            quo_v = {quo_v[PAD_W-2:0], 1'b0};
            if (rem_v >= {1'b0, den_reg})
            begin
                rem_v    = rem_v - {1'b0, den_reg};
                quo_v[0] = 1'b1;
            end
        end
        rem_next = rem_v[REM_W-2:0];
        quo_next = quo_v;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= PAD_W'(mag);
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (load)
        begin
            iter_reg <= '0;
        end
        else if (step)
        begin
            iter_reg <= iter_reg + 1'b1;
        end
    end

    assign quo_mag  = quo_reg[SUM_W-1:0];
    assign quotient = neg_reg ? $signed(-quo_mag) : $signed(quo_mag);
    assign last     = (iter_reg == ITER_W'(ITER - 1));

endmodule

// ----- rtl/core/ghf_datapath.sv -----
// ----------------------------------------------------------------------------
// ghf_datapath
// Config registers, grid store, window address walk, accumulator,
// divider and result registers.
// ----------------------------------------------------------------------------
module ghf_datapath #(
    parameter int MAX_ROWS    = 512,
    parameter int MAX_COLS    = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ghf_pkg::ghf_cmd_t                     cmd,
    output ghf_pkg::ghf_stat_t                    stat,
    input  logic [ghf_pkg::COORD_W-1:0]           row,
    input  logic [ghf_pkg::COORD_W-1:0]           col,
    input  logic signed [ghf_pkg::IN_VALUE_W-1:0] cell_value,
    input  logic                                  has_data,
    input  logic                                  cfg_write,
    input  logic [ghf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ghf_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                  done,
    output logic signed [ghf_pkg::FILL_W-1:0]     fill_value,
    output logic                                  filled,
    output logic [ghf_pkg::COUNT_W-1:0]           valid_count
);

    localparam int STORE_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int SUM_W   = STORE_W + 4;
    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WORD_W  = STORE_W + 1;
    localparam int SW      = ghf_pkg::SIZE_W;
    localparam int CW      = ghf_pkg::COORD_W;

    // config
    logic [SW-1:0]                 grid_rows_reg, grid_cols_reg;
    logic [ghf_pkg::THR_W-1:0]     min_valid_reg;
    logic [SW-1:0]                 rows_use, cols_use;
    logic [ghf_pkg::THR_W-1:0]     thr;

    // query
    logic [CW-1:0]                 row_reg, col_reg;
    logic [1:0]                    wr_reg, wc_reg;
    logic [SW:0]                   win_r, win_c;
    logic                          win_hit;
    logic                          rd_pend_reg, hit_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [ghf_pkg::COUNT_W-1:0]   cnt_reg;
    logic                          filled_reg;

    // store
    logic [ADDR_W-1:0]             clr_cnt_reg;
    logic [ADDR_W-1:0]             ram_addr, wr_addr, win_addr;
    logic                          ram_we, wr_hit;
    logic [WORD_W-1:0]             ram_wdata, ram_rdata;
    logic signed [STORE_W-1:0]     rd_val;

    // divider
    logic signed [SUM_W-1:0]       quotient;
    logic                          div_last;

    // results
    logic                          done_reg;
    logic signed [ghf_pkg::FILL_W-1:0] fill_value_reg;
    logic                          filled_out_reg;
    logic [ghf_pkg::COUNT_W-1:0]   valid_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= ghf_pkg::GRID_ROWS_RST;
            grid_cols_reg <= ghf_pkg::GRID_COLS_RST;
            min_valid_reg <= ghf_pkg::MIN_VALID_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ghf_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_data[SW-1:0];
                ghf_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_data[SW-1:0];
                ghf_pkg::REG_MIN_VALID: min_valid_reg <= cfg_data[ghf_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign rows_use = (32'(grid_rows_reg) > MAX_ROWS) ? SW'(MAX_ROWS) : grid_rows_reg;
    assign cols_use = (32'(grid_cols_reg) > MAX_COLS) ? SW'(MAX_COLS) : grid_cols_reg;
    assign thr      = (min_valid_reg == '0) ? ghf_pkg::THR_W'(1) : min_valid_reg;

    // write path
    assign wr_hit  = (SW'(row) < rows_use) && (SW'(col) < cols_use);
    assign wr_addr = ADDR_W'(32'(row) * 32'(MAX_COLS) + 32'(col));

    // window walk, offsets -1..+1; negative coordinates show in the top bit
    assign win_r    = (SW + 1)'(row_reg) + (SW + 1)'(wr_reg) - (SW + 1)'(1);
    assign win_c    = (SW + 1)'(col_reg) + (SW + 1)'(wc_reg) - (SW + 1)'(1);
    assign win_hit  = !win_r[SW] && !win_c[SW] &&
                      (win_r[SW-1:0] < rows_use) && (win_c[SW-1:0] < cols_use);
    assign win_addr = ADDR_W'(32'(win_r[SW-1:0]) * 32'(MAX_COLS) + 32'(win_c[SW-1:0]));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = win_addr;
        ram_wdata = {has_data, cell_value[STORE_W-1:0]};
        priority if (cmd.clear_en)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (cmd.wr_en)
        begin
            ram_we   = wr_hit;
            ram_addr = wr_addr;
        end
        else
        begin
            ram_we = 1'b0;
        end
    end

    ghf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk     (clk),
        .we      (ram_we),
        .addr    (ram_addr),
        .wr_data (ram_wdata),
        .rd_data (ram_rdata)
    );

    assign rd_val = ram_rdata[STORE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            wr_reg      <= '0;
            wc_reg      <= '0;
            rd_pend_reg <= 1'b0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.q_load)
            begin
                wr_reg <= '0;
                wc_reg <= '0;
            end
            else if (cmd.rd_en)
            begin
                if (wc_reg == 2'd2)
                begin
                    wc_reg <= '0;
                    wr_reg <= wr_reg + 1'b1;
                end
                else
                begin
                    wc_reg <= wc_reg + 1'b1;
                end
            end
            rd_pend_reg <= cmd.rd_en;
            hit_reg     <= cmd.rd_en && win_hit;
            done_reg    <= cmd.out_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
        begin
            row_reg <= row;
            col_reg <= col;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (rd_pend_reg && hit_reg && ram_rdata[STORE_W])
        begin
            sum_reg <= sum_reg + SUM_W'(rd_val);
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.div_load)
        begin
            filled_reg <= (cnt_reg >= thr);
        end
        if (cmd.out_en)
        begin
            fill_value_reg  <= filled_reg ? ghf_pkg::FILL_W'(quotient) : '0;
            filled_out_reg  <= filled_reg;
            valid_count_reg <= cnt_reg;
        end
    end

    ghf_divider #(
        .SUM_W (SUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .quotient (quotient),
        .last     (div_last)
    );

    assign stat.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign stat.win_last   = (wr_reg == 2'd2) && (wc_reg == 2'd2);
    assign stat.div_last   = div_last;

    assign done        = done_reg;
    assign fill_value  = fill_value_reg;
    assign filled      = filled_out_reg;
    assign valid_count = valid_count_reg;

endmodule

// ----- rtl/core/ghf_ctrl.sv -----
// ----------------------------------------------------------------------------
// ghf_ctrl
// Sequencer: clearing pass, write beats, window reads, divide, result.
// ----------------------------------------------------------------------------
module ghf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                op,
    input  ghf_pkg::ghf_stat_t  stat,
    output ghf_pkg::ghf_cmd_t   cmd,
    output logic                busy
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_LOAD  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == ghf_pkg::OP_QUERY)
                    begin
                        cmd.q_load = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
                if (stat.win_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                cmd.out_en = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- rtl/core/grid_hole_fill_mean3x3_unit.sv -----
// ----------------------------------------------------------------------------
// grid_hole_fill_mean3x3_unit
// Grid store with a masked 3x3 mean fill. Start is taken when busy is low.
// A write beat stores one cell and mark, if the cell lies inside the
// configured grid, and gives no result. A query beat reads the nine window
// cells one per cycle from the single-port grid RAM, then divides the sum by
// the valid count in a 6-bits-per-cycle divider; busy drops with done, so
// the next beat may start in the done cycle. done marks the result for one
// cycle and the receiver cannot stall it. After reset the block is busy
// while it clears the has-data marks; config writes are taken throughout.
// ----------------------------------------------------------------------------
module grid_hole_fill_mean3x3_unit #(
    parameter int MAX_ROWS    = 512,
    parameter int MAX_COLS    = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  op,
    input  logic [ghf_pkg::COORD_W-1:0]           row,
    input  logic [ghf_pkg::COORD_W-1:0]           col,
    input  logic signed [ghf_pkg::IN_VALUE_W-1:0] cell_value,
    input  logic                                  has_data,
    output logic                                  done,
    output logic signed [ghf_pkg::FILL_W-1:0]     fill_value,
    output logic                                  filled,
    output logic [ghf_pkg::COUNT_W-1:0]           valid_count,
    input  logic                                  cfg_write,
    input  logic [ghf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ghf_pkg::CFG_DATA_W-1:0]        cfg_data
);

    ghf_pkg::ghf_cmd_t  cmd;
    ghf_pkg::ghf_stat_t stat;

    ghf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ghf_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .row         (row),
        .col         (col),
        .cell_value  (cell_value),
        .has_data    (has_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .fill_value  (fill_value),
        .filled      (filled),
        .valid_count (valid_count)
    );

endmodule
